@@ design/date_difference_in_days_assert.svh @@
// Assertion macros for the top level of the date difference block.
`ifndef DATE_DIFFERENCE_IN_DAYS_ASSERT_SVH
`define DATE_DIFFERENCE_IN_DAYS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DDIFF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DDIFF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/ddiff_pkg.sv @@
// Types, constants and helper functions for the date difference block.
package ddiff_pkg;

   localparam int YearWidth  = 14;
   localparam int MonthWidth = 4;
   localparam int DomWidth   = 5;
   localparam int DiffWidth  = 23;
   localparam int LeapsWidth = 13;
   localparam int Q100Width  = 8;
   localparam int MstWidth   = 9;

   // floor(v / 100) for any 14-bit v is (v * 5243) >> 19.
   localparam int Recip100   = 5243;
   localparam int RecipShift = 19;
   localparam int RecipWidth = 13;
   localparam int ProdWidth  = YearWidth + RecipWidth;

   typedef logic [YearWidth-1:0]        year_type;
   typedef logic [MonthWidth-1:0]       month_type;
   typedef logic [DomWidth-1:0]         dom_type;
   typedef logic signed [DiffWidth-1:0] diff_type;
   typedef logic [DiffWidth-1:0]        daynum_type;
   typedef logic [LeapsWidth-1:0]       leaps_type;
   typedef logic [Q100Width-1:0]        q100_type;
   typedef logic [MstWidth-1:0]         mst_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_YEAR  = 2'd1,
      STATUS_BAD_MONTH = 2'd2,
      STATUS_BAD_DAY   = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_BASE_YEAR = 1'b0,
      CSR_LAST_YEAR = 1'b1
   } csr_index_type;

   localparam year_type BaseYearReset = YearWidth'(1900);
   localparam year_type LastYearReset = YearWidth'(2100);

   localparam daynum_type DaysPerYear = DiffWidth'(365);
   localparam dom_type    DaysFebLeap   = DomWidth'(29);
   localparam dom_type    DaysFebCommon = DomWidth'(28);
   localparam dom_type    DaysShortMon  = DomWidth'(30);

   localparam month_type MonthJan = MonthWidth'(1);
   localparam month_type MonthFeb = MonthWidth'(2);
   localparam month_type MonthMar = MonthWidth'(3);
   localparam month_type MonthApr = MonthWidth'(4);
   localparam month_type MonthJun = MonthWidth'(6);
   localparam month_type MonthSep = MonthWidth'(9);
   localparam month_type MonthNov = MonthWidth'(11);
   localparam month_type MonthDec = MonthWidth'(12);

   // Days before each month in a common year; codes above December hold the full year.
   localparam mst_type MonthStart [0:15] = '{
      9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
   };

   typedef struct packed {
      year_type   year;
      month_type  month;
      dom_type    day;
   } date_type;

   typedef struct packed {
      year_type   base_year;
      year_type   last_year;
      leaps_type  base_leaps;
   } cfg_type;

   typedef struct packed {
      daynum_type day_num;
      status_type status;
   } date_res_type;

   function automatic q100_type quot100(year_type v);
      logic [ProdWidth-1:0] prod;
      prod = ProdWidth'(v) * ProdWidth'(Recip100);
      return prod[RecipShift +: Q100Width];
   endfunction

   // Leap years in [0, p + 1) for p = year - 1, given q = floor(p / 100).
   function automatic leaps_type leap_count(year_type p, q100_type q);
      leaps_type s;
      s = LeapsWidth'(1) + LeapsWidth'(p >> 2) - LeapsWidth'(q) + LeapsWidth'(q >> 2);
      return s;
   endfunction

   function automatic leaps_type leaps_below(year_type y);
      year_type p;
      p = y - YearWidth'(1);
      return (y == '0) ? '0 : leap_count(p, quot100(p));
   endfunction

endpackage

@@ design/ddiff_if.sv @@
// Handshake interfaces for the request, response and register write channels.
interface ddiff_req_if;
   import ddiff_pkg::*;
   logic      valid;
   logic      ready;
   year_type  year_a;
   month_type month_a;
   dom_type   day_a;
   year_type  year_b;
   month_type month_b;
   dom_type   day_b;
   modport source (output valid, year_a, month_a, day_a, year_b, month_b, day_b,
                   input ready);
   modport sink   (input valid, year_a, month_a, day_a, year_b, month_b, day_b,
                   output ready);
endinterface

interface ddiff_rsp_if;
   import ddiff_pkg::*;
   logic       valid;
   logic       ready;
   diff_type   day_difference;
   status_type status_a;
   status_type status_b;
   modport source (output valid, day_difference, status_a, status_b, input ready);
   modport sink   (input valid, day_difference, status_a, status_b, output ready);
endinterface

interface ddiff_csr_if;
   import ddiff_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   year_type      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ design/ddiff_csr.sv @@
// Configuration registers, with the leap count of the base year kept alongside.
module ddiff_csr (
   input  logic           clock,
   input  logic           reset,
   ddiff_csr_if.sink      csr_if,
   output ddiff_pkg::cfg_type cfg
);
   import ddiff_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_BASE_YEAR: begin
               cfg_in.base_year  = csr_if.data;
               cfg_in.base_leaps = leaps_below(csr_if.data);
            end
            CSR_LAST_YEAR: begin
               cfg_in.last_year = csr_if.data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_year  <= BaseYearReset;
         cfg_ff.last_year  <= LastYearReset;
         cfg_ff.base_leaps <= leaps_below(BaseYearReset);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/ddiff_date_unit.sv @@
// Day number and validity code of one date.
module ddiff_date_unit (
   input  ddiff_pkg::date_type     date,
   input  ddiff_pkg::cfg_type      cfg,
   output ddiff_pkg::date_res_type res
);
   import ddiff_pkg::*;

   year_type   p;
   q100_type   q100;
   logic [6:0] r100;
   logic       leap;
   leaps_type  leaps_y;
   year_type   year_off;
   daynum_type year_part;
   daynum_type month_part;
   status_type status;

   assign p       = date.year - YearWidth'(1);
   assign q100    = quot100(p);
   assign r100    = 7'(p - YearWidth'(YearWidth'(q100) * YearWidth'(100)));
   assign leaps_y = leap_count(p, q100);

   // The year is a multiple of 100 exactly when p leaves 99; then only every fourth counts.
   assign leap = (date.year == '0) ||
                 ((p[1:0] == 2'b11) && ((r100 != 7'd99) || (q100[1:0] == 2'b11)));

   assign year_off  = date.year - cfg.base_year;
   assign year_part = (date.year > cfg.base_year) ?
                      (DiffWidth'(year_off) * DaysPerYear + DiffWidth'(leaps_y)
                       - DiffWidth'(cfg.base_leaps)) : '0;
   assign month_part = DiffWidth'(MonthStart[date.month]) +
                       DiffWidth'((date.month >= MonthMar) && leap);

   always_comb begin
      if ((date.year < cfg.base_year) || (date.year > cfg.last_year)) begin
         status = STATUS_BAD_YEAR;
      end else if (!(date.month inside {[MonthJan:MonthDec]})) begin
         status = STATUS_BAD_MONTH;
      end else if (date.day == '0) begin
         status = STATUS_BAD_DAY;
      end else if ((date.month == MonthFeb) &&
                   (date.day > (leap ? DaysFebLeap : DaysFebCommon))) begin
         status = STATUS_BAD_DAY;
      end else if ((date.month inside {MonthApr, MonthJun, MonthSep, MonthNov}) &&
                   (date.day > DaysShortMon)) begin
         status = STATUS_BAD_DAY;
      end else begin
         status = STATUS_OK;
      end
   end

   assign res.day_num = DiffWidth'(date.day) + year_part + month_part;
   assign res.status  = status;

endmodule

@@ design/date_difference_in_days.sv @@
// Top level of the Gregorian date difference block.
// The block takes two dates per request transfer and returns, one response transfer per
// request, the signed number of days from the second date to the first together with a
// validity code for each date. A new request is taken in every clock cycle as long as
// responses are taken. A request transfer loads the pair into the input register, and
// the pair moves into the result register, where its response is offered, once that is
// empty or being emptied. The throughput of one date pair per cycle while responses are
// taken is set by the single pass of date arithmetic between the input and result
// registers. While the response side stalls, the block holds one pair in the result
// register and one in the input register, and only then refuses further requests.
// The base year and last year registers are written through the register port and should
// only be changed while no request is in flight.
`include "date_difference_in_days_assert.svh"

module date_difference_in_days (
   input  logic         clock,
   input  logic         reset,
   ddiff_req_if.sink    req_if,
   ddiff_rsp_if.source  rsp_if,
   ddiff_csr_if.sink    csr_if
);
   import ddiff_pkg::*;

   cfg_type      cfg;

   // Input register: holds the accepted date pair.
   logic         s1_valid_ff;
   logic         s1_valid_in;
   date_type     s1_a_ff;
   date_type     s1_b_ff;

   // Result register: holds the response until the sink takes it.
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   diff_type     rsp_diff_ff;
   status_type   rsp_status_a_ff;
   status_type   rsp_status_b_ff;

   date_res_type res_a;
   date_res_type res_b;
   logic         advance;
   logic         req_take;

   ddiff_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   ddiff_date_unit u_date_a (
      .date (s1_a_ff),
      .cfg  (cfg),
      .res  (res_a)
   );

   ddiff_date_unit u_date_b (
      .date (s1_b_ff),
      .cfg  (cfg),
      .res  (res_b)
   );

   // The input register moves on whenever the result register is empty or being emptied,
   // so while responses are being taken the next request is never held up.
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_a_ff <= '{year: req_if.year_a, month: req_if.month_a, day: req_if.day_a};
         s1_b_ff <= '{year: req_if.year_b, month: req_if.month_b, day: req_if.day_b};
      end
   end

   // The difference is taken modulo two to the power of the result width.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_diff_ff     <= $signed(res_a.day_num - res_b.day_num);
         rsp_status_a_ff <= res_a.status;
         rsp_status_b_ff <= res_b.status;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.day_difference = rsp_diff_ff;
   assign rsp_if.status_a       = rsp_status_a_ff;
   assign rsp_if.status_b       = rsp_status_b_ff;

   // A full pipeline with a stalled response must refuse further requests.
   `DDIFF_ASSERT_NOW(a_stall_blocks_req, clock, reset, s1_valid_ff && rsp_valid_ff && !rsp_if.ready, !req_if.ready, "request taken while pipeline is full")
   // Every request transfer lands in the input register.
   `DDIFF_ASSERT_NEXT(a_take_loads_stage, clock, reset, req_take, s1_valid_ff, "accepted request lost")
   // A pair that moves on is offered as a response in the next cycle.
   `DDIFF_ASSERT_NEXT(a_advance_shows_rsp, clock, reset, advance, rsp_if.valid, "computed result not offered")

endmodule

@@ sim/tb_date_difference_in_days.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the Gregorian date difference block.
module tb_date_difference_in_days;
   import ddiff_pkg::*;

   // One date pair as it is driven onto the request channel.
   typedef struct packed {
      year_type  ya;
      month_type ma;
      dom_type   da;
      year_type  yb;
      month_type mb;
      dom_type   db;
   } date_pair_type;

   // What a single response transfer is expected to carry.
   typedef struct packed {
      diff_type   span;
      status_type st_a;
      status_type st_b;
   } outcome_type;

   // A row of the directed table. Where typed is set, the outcome is written out by hand
   // and used as it stands; otherwise the predictor supplies it.
   typedef struct packed {
      date_pair_type pair;
      bit            typed;
      outcome_type   outcome;
   } row_type;

   localparam int unsigned DaysInCommonYear = 365;
   localparam int unsigned YearMax          = 9999;
   localparam int unsigned IdleMax          = 7;
   localparam int unsigned SettleCycles     = 4;
   localparam int unsigned NumRows          = 20;

   // Days that precede each month code in a common year. Codes above December stand for
   // the whole year, and codes 0 and 1 add nothing.
   localparam int unsigned DaysBeforeMonth [16] = '{
      0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddiff_req_if req_if ();
   ddiff_rsp_if rsp_if ();
   ddiff_csr_if csr_if ();

   date_difference_in_days i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Our own copy of the two year registers, updated on every register transfer.
   int unsigned cfg_base = 1900;
   int unsigned cfg_last = 2100;

   // Outcomes of accepted requests, oldest first, waiting for their response transfer.
   outcome_type pending_results [$];
   int unsigned mismatches = 0;

   // While a burst flag is set, that side neither idles nor stalls. Each flag flips now and
   // then, so that long stretches at full rate alternate with stretches full of gaps.
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   int unsigned rsp_stall;

   // The directed table, walked at the register values that reset leaves behind
   // (base year 1900, last year 2100).
   row_type directed_rows [NumRows] = '{
      // Identical dates, and a difference of a single day within January.
      '{'{1900, 1, 1, 1900, 1, 1}, 1'b1, '{0, STATUS_OK, STATUS_OK}},
      '{'{1900, 1, 2, 1900, 1, 1}, 1'b1, '{1, STATUS_OK, STATUS_OK}},
      // One whole common year past the base.
      '{'{1901, 1, 1, 1900, 1, 1}, 1'b1, '{365, STATUS_OK, STATUS_OK}},
      // All fields at zero: the year lies below the base, so both dates fail on the year.
      '{'{0, 0, 0, 0, 0, 0}, 1'b1, '{0, STATUS_BAD_YEAR, STATUS_BAD_YEAR}},
      // Year at the bench maximum, month and day at their field maximum, against all zeros.
      '{'{9999, 15, 31, 0, 0, 0}, 1'b0, '{0, STATUS_OK, STATUS_OK}},
      // Month codes outside January to December.
      '{'{2000, 0, 15, 2000, 13, 1}, 1'b0, '{0, STATUS_OK, STATUS_OK}},
      '{'{2000, 14, 31, 2000, 15, 0}, 1'b0, '{0, STATUS_OK, STATUS_OK}},
      // Day zero, which fails on the day although the month is fine.
      '{'{2000, 3, 0, 2000, 1, 31}, 1'b0, '{0, STATUS_OK, STATUS_OK}},
      // The 29th of February in a century year that is not a leap year.
      '{'{1900, 2, 29, 1900, 2, 28}, 1'b1, '{1, STATUS_BAD_DAY, STATUS_OK}},
      // The 29th of February in a year divisible by 400, and the last year's February.
      '{'{2000, 2, 29, 2000, 3, 1}, 1'b0, '{0, STATUS_OK, STATUS_OK}},
      '{'{2100, 2, 29, 2100, 12, 31}, 1'b0, '{0, STATUS_OK, STATUS_OK}},
      // Just outside the valid years on either side.
      '{'{2101, 1, 1, 1899, 12, 31}, 1'b0, '{0, STATUS_OK, STATUS_OK}},
      // The 31st of a thirty-day month.
      '{'{2004, 4, 31, 2004, 4, 30}, 1'b1, '{1, STATUS_BAD_DAY, STATUS_OK}},
      '{'{1999, 6, 31, 1999, 9, 31}, 1'b0, '{0, STATUS_OK, STATUS_OK}},
      '{'{1999, 11, 31, 2001, 5, 31}, 1'b0, '{0, STATUS_OK, STATUS_OK}},
      // The widest span of valid dates both ways; then Feb 30 in a leap year and month ends.
      '{'{2100, 12, 31, 1900, 1, 1}, 1'b0, '{0, STATUS_OK, STATUS_OK}},
      '{'{1900, 1, 1, 2100, 12, 31}, 1'b0, '{0, STATUS_OK, STATUS_OK}},
      '{'{1996, 2, 29, 1996, 2, 30}, 1'b0, '{0, STATUS_OK, STATUS_OK}},
      '{'{2000, 12, 31, 2001, 1, 1}, 1'b0, '{0, STATUS_OK, STATUS_OK}},
      '{'{1950, 8, 31, 1950, 7, 31}, 1'b0, '{0, STATUS_OK, STATUS_OK}}
   };

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   function automatic bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   // Leap years among the years 0 to y - 1, year 0 being one of them. Each term counts the
   // multiples of 4, 100 and 400 that lie below y.
   function automatic longint leaps_before(int unsigned y);
      return longint'((y + 3) / 4) - longint'((y + 99) / 100) + longint'((y + 399) / 400);
   endfunction

   function automatic int unsigned month_length(int unsigned y, int unsigned m);
      case (m)
         MonthFeb:                     return leap_year(y) ? 29 : 28;
         MonthApr, MonthJun, MonthSep,
         MonthNov:                     return 30;
         default:                      return 31;
      endcase
   endfunction

   // Day number of a date counted from the configured base year. Years at or below the base
   // add no whole years, and the leap day counts from March onwards, whatever the month code.
   function automatic longint day_ordinal(int unsigned y, int unsigned m, int unsigned d);
      longint n;
      n = d;
      if (y > cfg_base)
         n += longint'(DaysInCommonYear) * longint'(y - cfg_base)
              + leaps_before(y) - leaps_before(cfg_base);
      n += DaysBeforeMonth[m];
      if (m >= MonthMar && leap_year(y))
         n += 1;
      return n;
   endfunction

   // The checks run in a fixed order: year range first, then month, then the day limit.
   function automatic status_type date_status(int unsigned y, int unsigned m, int unsigned d);
      if (y < cfg_base || y > cfg_last)
         return STATUS_BAD_YEAR;
      if (m < MonthJan || m > MonthDec)
         return STATUS_BAD_MONTH;
      if (d < 1 || d > month_length(y, m))
         return STATUS_BAD_DAY;
      return STATUS_OK;
   endfunction

   // The difference is worked out at full width and then cut to the port width, so that
   // any overflow wraps just as in two's complement.
   function automatic outcome_type predict_difference(date_pair_type p);
      outcome_type o;
      o.span = diff_type'(day_ordinal(p.ya, p.ma, p.da) - day_ordinal(p.yb, p.mb, p.db));
      o.st_a = date_status(p.ya, p.ma, p.da);
      o.st_b = date_status(p.yb, p.mb, p.db);
      return o;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------

   // Draws one date. Most dates are well formed and lie within the configured years; the
   // rest are either arbitrary field values or sit right on the edges of the year range
   // and of the month length, where the status checks change their verdict.
   task automatic draw_date(output year_type y, output month_type m, output dom_type d);
      int unsigned kind;
      int unsigned lo;
      int unsigned hi;
      int unsigned len;
      kind = $urandom_range(0, 99);
      if (cfg_base <= cfg_last) begin
         lo = cfg_base;
         hi = cfg_last;
      end else begin
         lo = 0;
         hi = YearMax;
      end
      if (kind < 70) begin
         y = year_type'($urandom_range(lo, hi));
         m = month_type'($urandom_range(MonthJan, MonthDec));
         d = dom_type'($urandom_range(1, month_length(y, m)));
      end else if (kind < 85) begin
         y = year_type'($urandom_range(0, YearMax));
         m = month_type'($urandom_range(0, 15));
         d = dom_type'($urandom_range(0, 31));
      end else begin
         case ($urandom_range(0, 3))
            0:       y = year_type'((lo == 0) ? 0 : lo - 1);
            1:       y = year_type'(lo);
            2:       y = year_type'(hi);
            default: y = year_type'((hi >= YearMax) ? YearMax : hi + 1);
         endcase
         m = ($urandom_range(0, 1) == 1) ? MonthFeb
                                         : month_type'($urandom_range(MonthJan, MonthDec));
         len = month_length(y, m);
         case ($urandom_range(0, 3))
            0:       d = dom_type'(len);
            1:       d = dom_type'((len >= 31) ? 0 : len + 1);
            2:       d = dom_type'(1);
            default: d = dom_type'(0);
         endcase
      end
   endtask

   // Puts one date pair on the request channel and waits for its transfer. The idle gap
   // comes first; with no gap the valid simply stays high from the previous transfer, so it
   // is never lowered and raised again within one time step.
   task automatic send_pair(date_pair_type p, outcome_type o);
      int unsigned gap;
      gap = req_burst ? 0 : $urandom_range(0, IdleMax);
      if ($urandom_range(0, 39) == 0)
         req_burst = !req_burst;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.year_a  <= p.ya;
      req_if.month_a <= p.ma;
      req_if.day_a   <= p.da;
      req_if.year_b  <= p.yb;
      req_if.month_b <= p.mb;
      req_if.day_b   <= p.db;
      do @(posedge clock); while (!req_if.ready);
      pending_results.push_back(o);
   endtask

   task automatic run_random(int unsigned count);
      date_pair_type p;
      repeat (count) begin
         draw_date(p.ya, p.ma, p.da);
         draw_date(p.yb, p.mb, p.db);
         send_pair(p, predict_difference(p));
      end
   endtask

   // Drops the request valid, waits for every outstanding response and then lets the
   // pipeline drain, so that a register write cannot overtake a request still in flight.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Writes both year registers back to back; the valid stays high across the two transfers.
   task automatic configure(int unsigned base, int unsigned last);
      csr_if.valid <= 1'b1;
      csr_if.index <= CSR_BASE_YEAR;
      csr_if.data  <= year_type'(base);
      do @(posedge clock); while (!csr_if.ready);
      cfg_base = base;
      csr_if.index <= CSR_LAST_YEAR;
      csr_if.data  <= year_type'(last);
      do @(posedge clock); while (!csr_if.ready);
      cfg_last = last;
      csr_if.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------------

   task automatic report(string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // Compares one response transfer, field by field, with the oldest outstanding outcome.
   task automatic check_response();
      outcome_type want;
      if (pending_results.size() == 0) begin
         report("response transfer with no request outstanding");
      end else begin
         want = pending_results.pop_front();
         if (rsp_if.day_difference !== want.span)
            report($sformatf("day_difference is %0d, should be %0d",
                             rsp_if.day_difference, want.span));
         if (rsp_if.status_a !== want.st_a)
            report($sformatf("status_a is %0d, should be %0d", rsp_if.status_a, want.st_a));
         if (rsp_if.status_b !== want.st_b)
            report($sformatf("status_b is %0d, should be %0d", rsp_if.status_b, want.st_b));
      end
   endtask

   // The response side. After each transfer it draws how many cycles to hold ready low
   // before taking the next response; ready is high again once that count has run out.
   always @(posedge clock) begin : rsp_side
      int unsigned draw;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         check_response();
         draw = rsp_burst ? 0 : $urandom_range(0, IdleMax);
         if ($urandom_range(0, 39) == 0)
            rsp_burst = !rsp_burst;
         rsp_stall    <= draw;
         rsp_if.ready <= (draw == 0);
      end else if (rsp_stall > 1) begin
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_stall    <= 0;
         rsp_if.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------------------------

   initial begin : main_sequence
      int unsigned base;
      // Every input of the block driven from here is given a known value before the first
      // clock edge; the response ready is set by the response side during reset.
      req_if.valid   = 1'b0;
      req_if.year_a  = '0;
      req_if.month_a = '0;
      req_if.day_a   = '0;
      req_if.year_b  = '0;
      req_if.month_b = '0;
      req_if.day_b   = '0;
      csr_if.valid   = 1'b0;
      csr_if.index   = CSR_BASE_YEAR;
      csr_if.data    = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows and a first random batch at the register values after reset.
      foreach (directed_rows[i])
         send_pair(directed_rows[i].pair,
                   directed_rows[i].typed ? directed_rows[i].outcome
                                          : predict_difference(directed_rows[i].pair));
      run_random(150);
      settle();

      // The widest year range the bench draws from, 1 to YearMax, so that day numbers grow large.
      configure(1, YearMax);
      run_random(120);
      settle();

      // Base above last: no year can pass the range check.
      configure(YearMax, 1);
      run_random(40);
      settle();

      // A range of a single year.
      configure(2000, 2000);
      run_random(60);
      settle();

      // The top year as both base and last, then a few arbitrary ranges.
      configure(YearMax, YearMax);
      run_random(30);
      settle();
      repeat (3) begin
         base = $urandom_range(1, YearMax);
         configure(base, $urandom_range(base, YearMax));
         run_random(45);
         settle();
      end

      // Everything has been answered by now; settle also waited for the pipeline to drain.
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // This limit lies far beyond the length of the slowest correct run and only catches a
   // block that has stopped answering.
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
